FILE: rtl/srq_pkg.sv
// Shared types and constants for the sensor reading qualifier.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package srq_pkg;

  localparam int ValW   = 32;
  localparam int DistW  = 31;
  localparam int CountW = 8;
  localparam int IdxW   = 8;
  localparam int DataW  = 32;

  localparam logic [IdxW-1:0] RegMinValue     = 8'd0;
  localparam logic [IdxW-1:0] RegMaxValue     = 8'd1;
  localparam logic [IdxW-1:0] RegMinEnable    = 8'd2;
  localparam logic [IdxW-1:0] RegMaxEnable    = 8'd3;
  localparam logic [IdxW-1:0] RegSnapDistance = 8'd4;
  localparam logic [IdxW-1:0] RegChangeThresh = 8'd5;
  localparam logic [IdxW-1:0] RegFaultAfter   = 8'd6;
  localparam logic [IdxW-1:0] RegClearAfter   = 8'd7;

  localparam logic signed [ValW-1:0] MinValueRst     = 32'sd0;
  localparam logic signed [ValW-1:0] MaxValueRst     = 32'sd6553600;
  localparam logic                   MinEnableRst    = 1'b1;
  localparam logic                   MaxEnableRst    = 1'b1;
  localparam logic [DistW-1:0]       SnapDistanceRst = 31'd13107;
  localparam logic [DistW-1:0]       ChangeThreshRst = 31'd32768;
  localparam logic [CountW-1:0]      FaultAfterRst   = 8'd3;
  localparam logic [CountW-1:0]      ClearAfterRst   = 8'd3;

  typedef struct packed {
    logic signed [ValW-1:0] min_value;
    logic signed [ValW-1:0] max_value;
    logic                   min_enable;
    logic                   max_enable;
    logic [DistW-1:0]       snap_distance;
    logic [DistW-1:0]       change_threshold;
    logic [CountW-1:0]      fault_after;
    logic [CountW-1:0]      clear_after;
  } cfg_t;

  typedef struct packed {
    logic                   reading_valid;
    logic signed [ValW-1:0] reading_value;
  } item_t;

  typedef struct packed {
    logic signed [ValW-1:0] last_reported;
    logic [CountW-1:0]      failure_count;
    logic [CountW-1:0]      success_count;
    logic                   fault_flag;
  } state_t;

  typedef struct packed {
    logic                   report;
    logic signed [ValW-1:0] reported_value;
    logic                   fault_active;
    logic                   fault_set_event;
    logic                   fault_clear_event;
  } result_t;

endpackage

FILE: rtl/srq_if.sv
// Channel interfaces: reading input, result output and register write port.
// Depends on srq_pkg for field widths.
`timescale 1ns / 1ps

interface srq_in_if;
  logic                            valid;
  logic                            ready;
  logic                            reading_valid;
  logic signed [srq_pkg::ValW-1:0] reading_value;

  modport source (output valid, reading_valid, reading_value, input ready);
  modport sink   (input valid, reading_valid, reading_value, output ready);
endinterface

interface srq_out_if;
  logic                            valid;
  logic                            ready;
  logic                            report;
  logic signed [srq_pkg::ValW-1:0] reported_value;
  logic                            fault_active;
  logic                            fault_set_event;
  logic                            fault_clear_event;

  modport source (output valid, report, reported_value, fault_active,
                  fault_set_event, fault_clear_event, input ready);
  modport sink   (input valid, report, reported_value, fault_active,
                  fault_set_event, fault_clear_event, output ready);
endinterface

interface srq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [srq_pkg::IdxW-1:0]         index;
  logic [srq_pkg::DataW-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/sensor_reading_qualifier.sv
// Top level of the sensor reading qualifier: input register, state, result register.
// Depends on srq_pkg, srq_if, srq_cfg_regs and srq_eval.
`timescale 1ns / 1ps
//
//  channel   direction  payload                                     handshake
//  in_ch     sink       reading_valid, reading_value                valid/ready
//  out_ch    source     report, reported_value, fault_active,       valid/ready
//                       fault_set_event, fault_clear_event
//  cfg_ch    sink       index, data                                 valid/ready
//
//  One reading per cycle while out_ch does not stall; a taken reading is held in the input
//  register and its result in the result register. The evaluation of one registered reading
//  against the channel state sets the pace. rst_n clears state, counters and the valid flags of
//  both register stages; registers take reset values. A stalled result holds the result register;
//  the input register then holds one more reading and in_ch.ready drops until the result is transferred.
//  cfg_ch is always ready.

module sensor_reading_qualifier (
  input logic      clk,
  input logic      rst_n,
  srq_in_if.sink   in_ch,
  srq_out_if.source out_ch,
  srq_cfg_if.sink  cfg_ch
);

  srq_pkg::cfg_t    cfg;
  srq_pkg::item_t   in_item_r;
  logic             in_vld_r;
  srq_pkg::state_t  state_r;
  srq_pkg::state_t  state_nxt;
  srq_pkg::result_t res_nxt;
  srq_pkg::result_t out_res_r;
  logic             out_vld_r;
  logic             advance;

  srq_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  srq_eval u_eval (
    .cfg       (cfg),
    .item      (in_item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.reading_valid <= in_ch.reading_valid;
      in_item_r.reading_value <= in_ch.reading_value;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.report            = out_res_r.report;
  assign out_ch.reported_value    = out_res_r.reported_value;
  assign out_ch.fault_active      = out_res_r.fault_active;
  assign out_ch.fault_set_event   = out_res_r.fault_set_event;
  assign out_ch.fault_clear_event = out_res_r.fault_clear_event;

endmodule

FILE: rtl/srq_cfg_regs.sv
// Configuration register file, written through the register write channel.
// Depends on srq_pkg and srq_cfg_if.
`timescale 1ns / 1ps

module srq_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  srq_cfg_if.sink       cfg_ch,
  output srq_pkg::cfg_t cfg
);

  srq_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid && cfg_ch.ready;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_value        <= srq_pkg::MinValueRst;
      cfg_r.max_value        <= srq_pkg::MaxValueRst;
      cfg_r.min_enable       <= srq_pkg::MinEnableRst;
      cfg_r.max_enable       <= srq_pkg::MaxEnableRst;
      cfg_r.snap_distance    <= srq_pkg::SnapDistanceRst;
      cfg_r.change_threshold <= srq_pkg::ChangeThreshRst;
      cfg_r.fault_after      <= srq_pkg::FaultAfterRst;
      cfg_r.clear_after      <= srq_pkg::ClearAfterRst;
    end else if (wr_en) begin
      case (cfg_ch.index)
        srq_pkg::RegMinValue:     cfg_r.min_value        <= $signed(cfg_ch.data);
        srq_pkg::RegMaxValue:     cfg_r.max_value        <= $signed(cfg_ch.data);
        srq_pkg::RegMinEnable:    cfg_r.min_enable       <= cfg_ch.data[0];
        srq_pkg::RegMaxEnable:    cfg_r.max_enable       <= cfg_ch.data[0];
        srq_pkg::RegSnapDistance: cfg_r.snap_distance    <= cfg_ch.data[srq_pkg::DistW-1:0];
        srq_pkg::RegChangeThresh: cfg_r.change_threshold <= cfg_ch.data[srq_pkg::DistW-1:0];
        srq_pkg::RegFaultAfter:   cfg_r.fault_after      <= cfg_ch.data[srq_pkg::CountW-1:0];
        srq_pkg::RegClearAfter:   cfg_r.clear_after      <= cfg_ch.data[srq_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/srq_eval.sv
// Per-reading evaluation: fault counting, bound snapping and deadband test.
// Depends on srq_pkg; purely combinational between the block's registers.
`timescale 1ns / 1ps

module srq_eval (
  input  srq_pkg::cfg_t    cfg,
  input  srq_pkg::item_t   item,
  input  srq_pkg::state_t  state,
  output srq_pkg::state_t  state_nxt,
  output srq_pkg::result_t result
);

  localparam int WideW = srq_pkg::ValW + 2;

  logic signed [WideW-1:0]          value_w;
  logic signed [WideW-1:0]          min_w;
  logic signed [WideW-1:0]          max_w;
  logic signed [WideW-1:0]          snap_w;
  logic signed [WideW-1:0]          lo_limit;
  logic signed [WideW-1:0]          hi_limit;
  logic                             snap_lo;
  logic                             snap_hi;
  logic signed [srq_pkg::ValW-1:0]  snapped;
  logic signed [WideW-1:0]          diff;
  logic [WideW-1:0]                 diff_abs;
  logic                             exceeded;
  logic                             entered;
  logic                             do_report;
  logic [srq_pkg::CountW-1:0]       fail_inc;
  logic [srq_pkg::CountW-1:0]       succ_inc;

  assign value_w  = WideW'(item.reading_value);
  assign min_w    = WideW'(cfg.min_value);
  assign max_w    = WideW'(cfg.max_value);
  assign snap_w   = $signed({3'b000, cfg.snap_distance});
  assign lo_limit = min_w + snap_w;
  assign hi_limit = max_w - snap_w;
  assign snap_lo  = cfg.min_enable && (value_w <= lo_limit);
  assign snap_hi  = cfg.max_enable && (value_w >= hi_limit);
  assign snapped  = snap_lo ? cfg.min_value :
                    snap_hi ? cfg.max_value : item.reading_value;

  assign diff     = WideW'(snapped) - WideW'(state.last_reported);
  assign diff_abs = diff[WideW-1] ? WideW'(-diff) : WideW'(diff);
  assign exceeded = diff_abs > {3'b000, cfg.change_threshold};
  assign entered  = (cfg.min_enable && snapped == cfg.min_value
                     && state.last_reported != cfg.min_value)
                 || (cfg.max_enable && snapped == cfg.max_value
                     && state.last_reported != cfg.max_value);
  assign do_report = item.reading_valid && (exceeded || entered);

  assign fail_inc = state.failure_count + 1'b1;
  assign succ_inc = state.success_count + 1'b1;

  always_comb begin
    state_nxt                = state;
    result.fault_set_event   = 1'b0;
    result.fault_clear_event = 1'b0;
    if (!item.reading_valid) begin
      state_nxt.success_count = '0;
      if (!state.fault_flag) begin
        if (fail_inc >= cfg.fault_after) begin
          state_nxt.fault_flag    = 1'b1;
          state_nxt.failure_count = '0;
          result.fault_set_event  = 1'b1;
        end else begin
          state_nxt.failure_count = fail_inc;
        end
      end
    end else begin
      state_nxt.failure_count = '0;
      if (state.fault_flag) begin
        if (succ_inc >= cfg.clear_after) begin
          state_nxt.fault_flag     = 1'b0;
          state_nxt.success_count  = '0;
          result.fault_clear_event = 1'b1;
        end else begin
          state_nxt.success_count = succ_inc;
        end
      end
    end
    if (do_report) begin
      state_nxt.last_reported = snapped;
    end
    result.report         = do_report;
    result.reported_value = state_nxt.last_reported;
    result.fault_active   = state_nxt.fault_flag;
  end

endmodule
